// File: rtl/core/diff_drive_odometry_core_assert.svh
// Assertion macros for the odometry core
`ifndef DIFF_DRIVE_ODOMETRY_CORE_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ODO_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("odometry assertion failed");
`define ODO_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("odometry check failed");
`else
`define ODO_ASSERT(label, clk, rst_n, prop)
`define ODO_ASSERT_NR(label, clk, prop)
`endif
`endif

// File: rtl/core/ddo_pkg.sv
// Package for the odometry core: types, constants and the arctangent table
package ddo_pkg;
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PRE,
        ST_ROT,
        ST_POST,
        ST_OUT
    } t_state;

    localparam logic [31:0] DIST_RESET  = 32'd1676239;
    localparam logic [31:0] ANGLE_RESET = 32'd166576282;
    localparam logic [31:0] INV_GAIN    = 32'd2608131496;
    localparam logic        REG_DIST    = 1'b0;
    localparam logic        REG_ANGLE   = 1'b1;

    function automatic logic [31:0] atan_lookup(input logic [4:0] i);
        logic [31:0] t;
        begin
            case (i)
                5'd0: t = 32'd536870912;
                5'd1: t = 32'd316933406;
                5'd2: t = 32'd167458907;
                5'd3: t = 32'd85004756;
                5'd4: t = 32'd42667331;
                5'd5: t = 32'd21354465;
                5'd6: t = 32'd10679838;
                5'd7: t = 32'd5340245;
                5'd8: t = 32'd2670163;
                5'd9: t = 32'd1335087;
                5'd10: t = 32'd667544;
                5'd11: t = 32'd333772;
                5'd12: t = 32'd166886;
                5'd13: t = 32'd83443;
                5'd14: t = 32'd41722;
                5'd15: t = 32'd20861;
                5'd16: t = 32'd10430;
                5'd17: t = 32'd5215;
                5'd18: t = 32'd2608;
                5'd19: t = 32'd1304;
                5'd20: t = 32'd652;
                5'd21: t = 32'd326;
                5'd22: t = 32'd163;
                5'd23: t = 32'd81;
                5'd24: t = 32'd41;
                5'd25: t = 32'd20;
                5'd26: t = 32'd10;
                5'd27: t = 32'd5;
                5'd28: t = 32'd3;
                5'd29: t = 32'd1;
                5'd30: t = 32'd1;
                default: t = 32'd0;
            endcase
            atan_lookup = t;
        end
    endfunction
endpackage

// File: rtl/core/ddo_serial_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle
module ddo_serial_mul #(
    parameter int AW = 34,
    parameter int BW = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [AW-1:0]      i_a,
    input  logic [BW-1:0]      i_b,
    output logic               o_done,
    output logic [AW+BW-1:0]   o_prod
);
    localparam int CW = $clog2(BW + 1);

    logic [AW+BW-1:0] r_acc, n_acc;
    logic [AW+BW-1:0] r_a, n_a;
    logic [BW-1:0]    r_b, n_b;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    always_comb begin
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_acc  = '0;
            n_a    = {{BW{1'b0}}, i_a};
            n_b    = i_b;
            n_cnt  = CW'(BW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) begin
                n_acc = r_acc + r_a;
            end
            n_a   = r_a << 1;
            n_b   = r_b >> 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// File: rtl/core/ddo_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per cycle
module ddo_cordic #(
    parameter int STEPS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [35:0] i_x,
    input  logic signed [32:0] i_z,
    output logic               o_done,
    output logic signed [35:0] o_x,
    output logic signed [35:0] o_y
);
    localparam int CW = 5;

    logic signed [35:0] r_x, n_x, r_y, n_y;
    logic signed [32:0] r_z, n_z;
    logic [CW-1:0]      r_i, n_i;
    logic               r_busy, n_busy, r_done, n_done;
    logic [4:0]         w_sh;
    logic signed [35:0] w_xs, w_ys;
    logic signed [32:0] w_t;

    assign w_sh = r_i[4:0];
    assign w_xs = r_x >>> w_sh;
    assign w_ys = r_y >>> w_sh;
    assign w_t  = $signed({1'b0, ddo_pkg::atan_lookup(w_sh)});

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        n_i = r_i;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_x = i_x;
            n_y = '0;
            n_z = i_z;
            n_i = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!r_z[32]) begin
                n_x = r_x - w_ys;
                n_y = r_y + w_xs;
                n_z = r_z - w_t;
            end else begin
                n_x = r_x + w_ys;
                n_y = r_y - w_xs;
                n_z = r_z + w_t;
            end
            n_i = r_i + 1'b1;
            if (r_i == CW'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_i    <= n_i;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_done = r_done;
    assign o_x = r_x;
    assign o_y = r_y;
endmodule

// File: rtl/core/diff_drive_odometry_core.sv
// Each accepted input runs the bit-serial multiplier three times and then the CORDIC
// (one step per cycle); a new input is not accepted until the previous result has
// moved to the output registers.
// Reset clears the pose, restores register defaults; no clearing pass.
// Input stall is high from acceptance until the result moves to the output registers.
module diff_drive_odometry_core #(
    parameter int TICK_WIDTH   = 16,
    parameter int CORDIC_STEPS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [TICK_WIDTH-1:0]  i_left_ticks,
    input  logic [TICK_WIDTH-1:0]  i_right_ticks,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [31:0]     o_step_x,
    output logic signed [31:0]     o_step_y,
    output logic signed [31:0]     o_step_turn,
    output logic signed [31:0]     o_pos_x,
    output logic signed [31:0]     o_pos_y,
    output logic [31:0]            o_yaw,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [0:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data
);
`include "diff_drive_odometry_core_assert.svh"
    localparam int TW = TICK_WIDTH + 1;
    localparam int MA = 40;
    localparam int PW = MA + 32;

    ddo_pkg::t_state r_state, n_state;
    logic [31:0] r_dist, r_angle;
    logic [31:0] r_xacc, r_yacc, r_head;
    logic [31:0] r_turn, n_turn;
    logic [31:0] r_mag, n_mag;
    logic        r_neg, n_neg;
    logic [1:0]  r_quad, n_quad;
    logic [1:0]  r_phase, n_phase;
    logic signed [TW-1:0] r_diff, n_diff;
    logic signed [31:0] r_sx, n_sx, r_sy, n_sy;
    logic signed [31:0] r_ostep_x, r_ostep_y;
    logic [31:0] r_oturn;
    logic        r_oval, n_oval;

    logic        w_mstart, w_mdone, w_cstart, w_cdone;
    logic [MA-1:0] w_ma;
    logic [31:0] w_mb;
    logic [PW-1:0] w_prod;
    logic signed [35:0] w_cx, w_rx, w_ry;
    logic signed [32:0] w_cz;
    logic signed [TW-1:0] w_l, w_r, w_sum;
    logic [31:0] w_half, w_mid, w_resid;
    logic [1:0]  w_q;
    logic signed [35:0] w_qx, w_qy;
    logic signed [33:0] w_fx, w_fy;
    logic [PW-1:0] w_magfull;

    assign w_l   = TW'($signed(i_left_ticks));
    assign w_r   = TW'($signed(i_right_ticks));
    assign w_sum = w_l + w_r;
    assign w_half  = {r_turn[31], r_turn[31:1]};
    assign w_mid   = r_head + w_half;
    assign w_q     = 2'((w_mid + 32'h2000_0000) >> 30);
    assign w_resid = w_mid - {w_q, 30'd0};
    assign w_cz    = $signed({w_resid[31], w_resid});
    assign w_magfull = w_prod >> 17;
    assign w_cx = $signed({3'd0, w_prod[62:30]});

    always_comb begin
        case (r_quad)
            2'd1: begin w_qx = -w_ry; w_qy = w_rx; end
            2'd2: begin w_qx = -w_rx; w_qy = -w_ry; end
            2'd3: begin w_qx = w_ry; w_qy = -w_rx; end
            default: begin w_qx = w_rx; w_qy = w_ry; end
        endcase
        w_fx = 34'(w_qx >>> 2);
        w_fy = 34'(w_qy >>> 2);
        if (r_neg) begin
            w_fx = -w_fx;
            w_fy = -w_fy;
        end
    end

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > 34'sd2147483647) sat34 = 32'sh7fff_ffff;
        else if (v < -34'sd2147483648) sat34 = 32'sh8000_0000;
        else sat34 = v[31:0];
    endfunction

    always_comb begin
        n_state = r_state;
        n_turn = r_turn;
        n_mag = r_mag;
        n_neg = r_neg;
        n_quad = r_quad;
        n_phase = r_phase;
        n_diff = r_diff;
        n_sx = r_sx;
        n_sy = r_sy;
        n_oval = r_oval;
        w_mstart = 1'b0;
        w_cstart = 1'b0;
        w_ma = '0;
        w_mb = '0;
        if (r_oval && !i_stall) n_oval = 1'b0;
        case (r_state)
            ddo_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_neg = w_sum[TW-1];
                    n_diff = w_r - w_l;
                    w_ma = MA'(w_sum[TW-1] ? -w_sum : w_sum);
                    w_mb = r_dist;
                    w_mstart = 1'b1;
                    n_phase = 2'd0;
                    n_state = ddo_pkg::ST_MUL;
                end
            end
            ddo_pkg::ST_MUL: begin
                if (w_mdone) begin
                    if (r_phase == 2'd0) begin
                        n_mag = (w_magfull > PW'(32'h7fff_ffff)) ? 32'h7fff_ffff
                                                                 : w_magfull[31:0];
                        w_ma = MA'($signed(r_diff));
                        w_mb = r_angle;
                        w_mstart = 1'b1;
                        n_phase = 2'd1;
                    end else begin
                        n_turn = w_prod[39:8];
                        n_state = ddo_pkg::ST_PRE;
                    end
                end
            end
            ddo_pkg::ST_PRE: begin
                if (r_phase == 2'd1) begin
                    n_quad = w_q;
                    w_ma = MA'(r_mag);
                    w_mb = ddo_pkg::INV_GAIN;
                    w_mstart = 1'b1;
                    n_phase = 2'd2;
                end else if (w_mdone) begin
                    w_cstart = 1'b1;
                    n_state = ddo_pkg::ST_ROT;
                end
            end
            ddo_pkg::ST_ROT: begin
                if (w_cdone) n_state = ddo_pkg::ST_POST;
            end
            ddo_pkg::ST_POST: begin
                n_sx = sat34(w_fx);
                n_sy = sat34(w_fy);
                n_state = ddo_pkg::ST_OUT;
            end
            ddo_pkg::ST_OUT: begin
                if (!r_oval) begin
                    n_oval = 1'b1;
                    n_state = ddo_pkg::ST_IDLE;
                end
            end
            default: n_state = ddo_pkg::ST_IDLE;
        endcase
    end

    logic signed [33:0] w_px, w_py;
    assign w_px = 34'($signed(r_xacc)) + 34'(r_sx);
    assign w_py = 34'($signed(r_yacc)) + 34'(r_sy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddo_pkg::ST_IDLE;
            r_oval  <= 1'b0;
            r_dist  <= ddo_pkg::DIST_RESET;
            r_angle <= ddo_pkg::ANGLE_RESET;
            r_xacc  <= '0;
            r_yacc  <= '0;
            r_head  <= '0;
            r_phase <= '0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
            r_phase <= n_phase;
            if (i_cfg_valid) begin
                if (i_cfg_index == ddo_pkg::REG_DIST) r_dist <= i_cfg_data;
                else r_angle <= i_cfg_data;
            end
            if (r_state == ddo_pkg::ST_OUT && !r_oval) begin
                r_xacc    <= sat34(w_px);
                r_yacc    <= sat34(w_py);
                r_head    <= r_head + r_turn;
                r_ostep_x <= r_sx;
                r_ostep_y <= r_sy;
                r_oturn   <= r_turn;
            end
        end
        r_turn <= n_turn;
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_quad <= n_quad;
        r_diff <= n_diff;
        r_sx   <= n_sx;
        r_sy   <= n_sy;
    end

    ddo_serial_mul #(.AW(MA), .BW(32)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart),
        .i_a(w_ma), .i_b(w_mb), .o_done(w_mdone), .o_prod(w_prod)
    );

    ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_cstart),
        .i_x(w_cx), .i_z(w_cz), .o_done(w_cdone), .o_x(w_rx), .o_y(w_ry)
    );

    assign o_stall     = (r_state != ddo_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_oval;
    assign o_step_x    = r_ostep_x;
    assign o_step_y    = r_ostep_y;
    assign o_step_turn = r_oturn;
    assign o_pos_x     = r_xacc;
    assign o_pos_y     = r_yacc;
    assign o_yaw       = r_head;

    `ODO_ASSERT(a_no_accept_busy, i_clk, i_rst_n,
        (r_state != ddo_pkg::ST_IDLE) |-> o_stall)
    `ODO_ASSERT(a_out_hold, i_clk, i_rst_n,
        (o_valid && i_stall) |=> (o_valid && $stable(o_pos_x) && $stable(o_yaw)))
    `ODO_ASSERT(a_cordic_done, i_clk, i_rst_n,
        w_cdone |-> (r_state == ddo_pkg::ST_ROT))
endmodule
